// ===== design/rpc_pkg.sv =====
// Shared types, constants and the arctangent table for the rectangular/polar converter.
package rpc_pkg;

    localparam int DEG_FRAC = 16;
    localparam int ANG_W = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam logic [ANG_W-1:0] ANG_90 = 16'd11520;
    localparam logic [ANG_W-1:0] ANG_180 = 16'd23040;
    localparam logic [ANG_W-1:0] ANG_360 = 16'd46080;
    localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;

    // z in degrees, 16 fractional bits; range fits 28 bits signed comfortably
    localparam int ZW = 28;

    typedef enum logic [1:0] {
        CLS_ZERO_Y,
        CLS_X_AXIS,
        CLS_GENERAL
    } cls_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0: r = 28'sd2949120;
            1: r = 28'sd1740967;
            2: r = 28'sd919879;
            3: r = 28'sd466945;
            4: r = 28'sd234379;
            5: r = 28'sd117304;
            6: r = 28'sd58666;
            7: r = 28'sd29335;
            8: r = 28'sd14668;
            9: r = 28'sd7334;
            10: r = 28'sd3667;
            11: r = 28'sd1833;
            12: r = 28'sd917;
            13: r = 28'sd458;
            14: r = 28'sd229;
            15: r = 28'sd115;
            16: r = 28'sd57;
            17: r = 28'sd29;
            18: r = 28'sd14;
            19: r = 28'sd7;
            20: r = 28'sd4;
            21: r = 28'sd2;
            22: r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/rpc_front.sv =====
// Front part: accept words, take absolute values, classify the vector, square the coordinates.
module rpc_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic [rpc_pkg::ANG_W-1:0]     in_ang,
    output logic                          f_valid,
    input  logic                          f_ready,
    output logic                          f_func,
    output logic [COORD_WIDTH-1:0]        f_ax,
    output logic [COORD_WIDTH-1:0]        f_ay,
    output logic [2*COORD_WIDTH:0]        f_sq,
    output logic                          f_xneg,
    output logic                          f_xzero,
    output logic                          f_yneg,
    output logic                          f_yzero,
    output logic [rpc_pkg::ANG_W-1:0]     f_ang
);
    localparam int CW = COORD_WIDTH;

    // stage 1: absolute values and classification
    logic s1_valid_reg, s1_valid_next;
    logic s1_func_reg, s1_xneg_reg, s1_xzero_reg, s1_yneg_reg, s1_yzero_reg;
    logic [CW-1:0] s1_ax_reg, s1_ay_reg;
    logic [rpc_pkg::ANG_W-1:0] s1_ang_reg;
    // stage 2: squares summed
    logic s2_valid_reg, s2_valid_next;
    logic s2_func_reg, s2_xneg_reg, s2_xzero_reg, s2_yneg_reg, s2_yzero_reg;
    logic [CW-1:0] s2_ax_reg, s2_ay_reg;
    logic [2*CW:0] s2_sq_reg;
    logic [rpc_pkg::ANG_W-1:0] s2_ang_reg;

    logic adv2, adv1;
    logic [CW-1:0] ax_c, ay_c;
    logic [rpc_pkg::ANG_W-1:0] ang_wrap;
    logic [2*CW-1:0] sqx_c, sqy_c;

    assign adv2 = !s2_valid_reg || f_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    assign ax_c = in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
    assign ay_c = in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
    assign ang_wrap = (in_ang >= rpc_pkg::ANG_360) ? in_ang - rpc_pkg::ANG_360 : in_ang;

    // full-width squares
    assign sqx_c = s1_ax_reg * s1_ax_reg;
    assign sqy_c = s1_ay_reg * s1_ay_reg;

    assign s1_valid_next = adv1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_func_reg  <= in_func;
            s1_ax_reg    <= ax_c;
            s1_ay_reg    <= ay_c;
            s1_xneg_reg  <= in_x[CW-1];
            s1_yneg_reg  <= in_y[CW-1];
            s1_xzero_reg <= (in_x == '0);
            s1_yzero_reg <= (in_y == '0);
            s1_ang_reg   <= ang_wrap;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_ax_reg    <= s1_ax_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_xneg_reg  <= s1_xneg_reg;
            s2_yneg_reg  <= s1_yneg_reg;
            s2_xzero_reg <= s1_xzero_reg;
            s2_yzero_reg <= s1_yzero_reg;
            s2_ang_reg   <= s1_ang_reg;
            s2_sq_reg    <= {1'b0, sqx_c} + {1'b0, sqy_c};
        end
    end

    assign f_valid = s2_valid_reg;
    assign f_func  = s2_func_reg;
    assign f_ax    = s2_ax_reg;
    assign f_ay    = s2_ay_reg;
    assign f_sq    = s2_sq_reg;
    assign f_xneg  = s2_xneg_reg;
    assign f_xzero = s2_xzero_reg;
    assign f_yneg  = s2_yneg_reg;
    assign f_yzero = s2_yzero_reg;
    assign f_ang   = s2_ang_reg;

endmodule

// ===== design/rpc_queue.sv =====
// Two-entry queue of front-part words between the front and the back.
module rpc_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== design/rpc_back.sv =====
// Back part: pipelined square root, then one shared CORDIC pipeline for vectoring or rotation.
module rpc_back #(
    parameter int COORD_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          b_valid,
    output logic                          b_ready,
    input  logic                          b_func,
    input  logic [COORD_WIDTH-1:0]        b_ax,
    input  logic [COORD_WIDTH-1:0]        b_ay,
    input  logic [2*COORD_WIDTH:0]        b_sq,
    input  logic                          b_xneg,
    input  logic                          b_xzero,
    input  logic                          b_yneg,
    input  logic                          b_yzero,
    input  logic [rpc_pkg::ANG_W-1:0]     b_ang,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_WIDTH-1:0]        magnitude,
    output logic [rpc_pkg::ANG_W-1:0]     angle_out,
    output logic signed [COORD_WIDTH-1:0] new_x,
    output logic signed [COORD_WIDTH-1:0] new_y,
    output logic                          saturated
);
    localparam int CW = COORD_WIDTH;
    localparam int SW = 2 * CW + 1;          // sum of squares
    localparam int RW = CW + 1;              // root width
    localparam int NS = (SW + 1) / 2;        // root steps, one bit each
    localparam int NI = (ITERATIONS < rpc_pkg::ATAN_ENTRIES) ? ITERATIONS
                                                             : rpc_pkg::ATAN_ENTRIES;
    localparam int DF = rpc_pkg::DEG_FRAC;
    // CORDIC datapath width: coordinates with guard bits, gain and sign headroom
    localparam int VW = CW + DF + 4;
    localparam int ZW = rpc_pkg::ZW;
    localparam int AW = rpc_pkg::ANG_W;
    localparam int PW = RW + 30;             // magnitude times gain inverse

    typedef struct packed {
        logic          func;
        logic          xneg;
        logic          xzero;
        logic          yneg;
        logic          yzero;
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [AW-1:0] ang;
    } ctl_t;

    // global stall: every stage moves together when the output slot frees
    logic adv;

    // ---------------- square root, one result bit per stage ----------------
    logic          sq_v_reg  [NS+1];
    ctl_t          sq_c_reg  [NS+1];
    logic [SW-1:0] sq_s_reg  [NS+1];
    logic [SW:0]   sq_rem_reg[NS+1];
    logic [RW-1:0] sq_r_reg  [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                sq_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= b_valid;
            for (int k = 1; k <= NS; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_c_reg[0]   <= '{func: b_func, xneg: b_xneg, xzero: b_xzero, yneg: b_yneg,
                               yzero: b_yzero, ax: b_ax, ay: b_ay, ang: b_ang};
            sq_s_reg[0]   <= b_sq;
            sq_rem_reg[0] <= '0;
            sq_r_reg[0]   <= '0;
        end
    end

    // restoring root: bring down two bits, try 4r+1
    for (genvar g = 0; g < NS; g++)
    begin : g_sqrt
        localparam int HI = 2 * (NS - 1 - g);
        logic [2*NS-1:0] sext_s;
        logic [SW:0]     rem_sh;
        logic [SW:0]     trial;
        assign sext_s = (2*NS)'(sq_s_reg[g]);
        assign rem_sh = {sq_rem_reg[g][SW-2:0], sext_s[HI+1], sext_s[HI]};
        assign trial  = (SW+1)'({sq_r_reg[g][RW-2:0], 2'b01});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c_reg[g+1] <= sq_c_reg[g];
                sq_s_reg[g+1] <= sq_s_reg[g];
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[g+1] <= rem_sh - trial;
                    sq_r_reg[g+1]   <= {sq_r_reg[g][RW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[g+1] <= rem_sh;
                    sq_r_reg[g+1]   <= {sq_r_reg[g][RW-2:0], 1'b0};
                end
            end
        end
    end

    // rounding: remainder s - r*r > r means round up
    logic [RW-1:0] m_round;
    assign m_round = sq_r_reg[NS] + RW'(sq_rem_reg[NS] > (SW+1)'(sq_r_reg[NS]));

    // ---------------- preparation: gain product and start vector ----------
    logic          p1_v_reg;
    ctl_t          p1_c_reg;
    logic [RW-1:0] p1_m_reg;
    logic [PW-1:0] p1_prod_reg;
    logic signed [ZW-1:0] p1_t_reg;
    logic          p1_flip_reg;

    logic signed [ZW-1:0] t_raw, t_adj;
    logic flip_c;
    always_comb
    begin
        t_raw = ZW'(signed'({1'b0, sq_c_reg[NS].ang, 9'd0}));
        t_adj = t_raw;
        flip_c = 1'b0;
        if (t_raw > (ZW'(90) <<< DF))
        begin
            if (t_raw <= (ZW'(270) <<< DF))
            begin
                t_adj = t_raw - (ZW'(180) <<< DF);
                flip_c = 1'b1;
            end
            else
                t_adj = t_raw - (ZW'(360) <<< DF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (adv)
            p1_v_reg <= sq_v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_c_reg    <= sq_c_reg[NS];
            p1_m_reg    <= m_round;
            p1_prod_reg <= PW'(m_round) * PW'(rpc_pkg::GAIN_INV_Q30);
            p1_t_reg    <= t_adj;
            p1_flip_reg <= flip_c;
        end
    end

    // ---------------- CORDIC stages ----------------
    logic                 cd_v_reg [NI+1];
    ctl_t                 cd_c_reg [NI+1];
    logic [RW-1:0]        cd_m_reg [NI+1];
    logic                 cd_f_reg [NI+1];
    logic signed [VW-1:0] cd_x_reg [NI+1];
    logic signed [VW-1:0] cd_y_reg [NI+1];
    logic signed [ZW-1:0] cd_z_reg [NI+1];

    logic [PW-1:0] prod_rnd;
    assign prod_rnd = p1_prod_reg + PW'(1 << 13);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NI; k++)
                cd_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            cd_v_reg[0] <= p1_v_reg;
            for (int k = 1; k <= NI; k++)
                cd_v_reg[k] <= cd_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_c_reg[0] <= p1_c_reg;
            cd_m_reg[0] <= p1_m_reg;
            cd_f_reg[0] <= p1_flip_reg;
            if (p1_c_reg.func)
            begin
                // rotation: start on x axis at magnitude times gain inverse
                cd_x_reg[0] <= VW'(signed'({1'b0, prod_rnd[PW-1:14]}));
                cd_y_reg[0] <= '0;
                cd_z_reg[0] <= p1_t_reg;
            end
            else
            begin
                cd_x_reg[0] <= VW'(signed'({1'b0, p1_c_reg.ax, DF'(0)}));
                cd_y_reg[0] <= VW'(signed'({1'b0, p1_c_reg.ay, DF'(0)}));
                cd_z_reg[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < NI; g++)
    begin : g_cordic
        logic signed [VW-1:0] dx, dy;
        logic                 pos;
        assign dx = cd_y_reg[g] >>> g;
        assign dy = cd_x_reg[g] >>> g;
        // vectoring drives y to zero, rotation drives z to zero
        assign pos = cd_c_reg[g].func ? (cd_z_reg[g] >= 0) : (cd_y_reg[g] <= 0);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_c_reg[g+1] <= cd_c_reg[g];
                cd_m_reg[g+1] <= cd_m_reg[g];
                cd_f_reg[g+1] <= cd_f_reg[g];
                if (cd_c_reg[g].func)
                begin
                    if (pos)
                    begin
                        cd_x_reg[g+1] <= cd_x_reg[g] - dx;
                        cd_y_reg[g+1] <= cd_y_reg[g] + dy;
                        cd_z_reg[g+1] <= cd_z_reg[g] - rpc_pkg::atan_deg(g);
                    end
                    else
                    begin
                        cd_x_reg[g+1] <= cd_x_reg[g] + dx;
                        cd_y_reg[g+1] <= cd_y_reg[g] - dy;
                        cd_z_reg[g+1] <= cd_z_reg[g] + rpc_pkg::atan_deg(g);
                    end
                end
                else
                begin
                    if (!pos)
                    begin
                        cd_x_reg[g+1] <= cd_x_reg[g] + dx;
                        cd_y_reg[g+1] <= cd_y_reg[g] - dy;
                        cd_z_reg[g+1] <= cd_z_reg[g] + rpc_pkg::atan_deg(g);
                    end
                    else
                    begin
                        cd_x_reg[g+1] <= cd_x_reg[g] - dx;
                        cd_y_reg[g+1] <= cd_y_reg[g] + dy;
                        cd_z_reg[g+1] <= cd_z_reg[g] - rpc_pkg::atan_deg(g);
                    end
                end
            end
        end
    end

    // ---------------- finishing: quadrant rule, rounding, clipping ----------
    ctl_t fc;
    logic signed [ZW-1:0] zc;
    logic [AW-1:0] a_q, ang_c;
    logic signed [VW-1:0] rx, ry, rxf, ryf;
    logic [CW-1:0] nx_c, ny_c;
    logic sat_c;
    localparam logic signed [VW-1:0] HI_LIM = VW'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [VW-1:0] LO_LIM = -HI_LIM - VW'(1);

    always_comb
    begin
        fc = cd_c_reg[NI];
        zc = cd_z_reg[NI];
        if (zc < 0)
            zc = '0;
        if (zc > (ZW'(90) <<< DF))
            zc = ZW'(90) <<< DF;
        a_q = AW'((zc + ZW'(256)) >>> 9);
        if (fc.xzero)
            a_q = rpc_pkg::ANG_90;
        if (fc.yzero)
            ang_c = fc.xneg ? rpc_pkg::ANG_180 : '0;
        else if (!fc.yneg)
            ang_c = fc.xneg ? rpc_pkg::ANG_180 - a_q : a_q;
        else if (!fc.xneg && !fc.xzero)
            ang_c = (a_q == '0) ? '0 : rpc_pkg::ANG_360 - a_q;
        else
            ang_c = rpc_pkg::ANG_180 + a_q;

        rx = (cd_x_reg[NI] + VW'(1 << 15)) >>> DF;
        ry = (cd_y_reg[NI] + VW'(1 << 15)) >>> DF;
        rxf = cd_f_reg[NI] ? -rx : rx;
        ryf = cd_f_reg[NI] ? -ry : ry;
        sat_c = 1'b0;
        if (rxf > HI_LIM)
        begin
            nx_c = CW'(HI_LIM);
            sat_c = 1'b1;
        end
        else if (rxf < LO_LIM)
        begin
            nx_c = CW'(LO_LIM);
            sat_c = 1'b1;
        end
        else
            nx_c = CW'(rxf);
        if (ryf > HI_LIM)
        begin
            ny_c = CW'(HI_LIM);
            sat_c = 1'b1;
        end
        else if (ryf < LO_LIM)
        begin
            ny_c = CW'(LO_LIM);
            sat_c = 1'b1;
        end
        else
            ny_c = CW'(ryf);
    end

    // output register; the whole back pipe holds while it is full and stalled
    logic          o_v_reg;
    logic [CW-1:0] o_m_reg, o_x_reg, o_y_reg;
    logic [AW-1:0] o_a_reg;
    logic          o_s_reg;

    assign adv = !o_v_reg || out_ready;
    assign b_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (adv)
            o_v_reg <= cd_v_reg[NI];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_m_reg <= CW'(cd_m_reg[NI]);
            o_a_reg <= fc.func ? '0 : ang_c;
            o_x_reg <= fc.func ? nx_c : '0;
            o_y_reg <= fc.func ? ny_c : '0;
            o_s_reg <= fc.func & sat_c;
        end
    end

    assign out_valid = o_v_reg;
    assign magnitude = o_m_reg;
    assign angle_out = o_a_reg;
    assign new_x     = signed'(o_x_reg);
    assign new_y     = signed'(o_y_reg);
    assign saturated = o_s_reg;

endmodule

// ===== design/rect_polar_converter_unit.sv =====
// Top level of the rectangular/polar converter: front, queue and back part.
//
// Input channel (in_valid/in_ready) takes one word: func, coord_x, coord_y and
// angle_in. func 0 gives magnitude and angle_out in degrees Q9.7; func 1 gives
// new_x/new_y at angle_in with the input's magnitude, clipped, with saturated
// set on clipping. Output channel (out_valid/out_ready) gives one word per input.
// Throughput: one word per cycle while out_ready is high, set by the fully
// pipelined datapath: one square-root stage per result bit and one CORDIC
// stage per iteration. Path of a word without stalls: the second front stage,
// the queue, the root input register, (COORD_WIDTH + 1) root stages, the gain
// stage, the CORDIC input register, the CORDIC stages and the output register.
// Reset clears every valid flag and the queue; no word is in flight after it.
// When the receiver stalls, the output register holds its word and the whole
// back pipeline freezes; the queue then fills, the front part holds, and
// in_ready drops once the front stages are full. Words are never lost or doubled.
module rect_polar_converter_unit #(
    parameter int ITERATIONS = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic [15:0]                   angle_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_WIDTH-1:0]        magnitude,
    output logic [15:0]                   angle_out,
    output logic signed [COORD_WIDTH-1:0] new_x,
    output logic signed [COORD_WIDTH-1:0] new_y,
    output logic                          saturated
);
    localparam int CW = COORD_WIDTH;
    localparam int AW = rpc_pkg::ANG_W;

    // word passed from the front part to the back part
    typedef struct packed {
        logic            func;
        logic [CW-1:0]   ax;
        logic [CW-1:0]   ay;
        logic [2*CW:0]   sq;
        logic            xneg;
        logic            xzero;
        logic            yneg;
        logic            yzero;
        logic [AW-1:0]   ang;
    } fword_t;

    fword_t f_word, b_word;
    logic f_valid, f_ready, b_valid, b_ready;

    rpc_front #(.COORD_WIDTH(CW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_func  (func),
        .in_x     (coord_x),
        .in_y     (coord_y),
        .in_ang   (angle_in),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_func   (f_word.func),
        .f_ax     (f_word.ax),
        .f_ay     (f_word.ay),
        .f_sq     (f_word.sq),
        .f_xneg   (f_word.xneg),
        .f_xzero  (f_word.xzero),
        .f_yneg   (f_word.yneg),
        .f_yzero  (f_word.yzero),
        .f_ang    (f_word.ang)
    );

    // decouple the two halves so each may stall on its own
    rpc_queue #(.W($bits(fword_t))) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_word),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_word)
    );

    rpc_back #(.COORD_WIDTH(CW), .ITERATIONS(ITERATIONS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_valid   (b_valid),
        .b_ready   (b_ready),
        .b_func    (b_word.func),
        .b_ax      (b_word.ax),
        .b_ay      (b_word.ay),
        .b_sq      (b_word.sq),
        .b_xneg    (b_word.xneg),
        .b_xzero   (b_word.xzero),
        .b_yneg    (b_word.yneg),
        .b_yzero   (b_word.yzero),
        .b_ang     (b_word.ang),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .magnitude (magnitude),
        .angle_out (angle_out),
        .new_x     (new_x),
        .new_y     (new_y),
        .saturated (saturated)
    );

endmodule
